// ===== hw/rtl/vsis_pkg.sv =====
// vsis_pkg: shared types and constants for the value set interval summary.
// Used by the controller, the datapath and the top level; no dependencies.
package vsis_pkg;

  localparam int VAL_W = 7;
  localparam int DEF_VALUE_COUNT = 128;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic insert;     // mark the incoming value as seen
    logic scan_init;  // rewind the scan pointer and clear run tracking
    logic scan_step;  // examine one bitmap position
    logic flush;      // emit the held run as the final one
  } ctrl_cmd_t;

  typedef struct packed {
    logic at_last;    // scan pointer sits on the top bitmap position
  } ctrl_sts_t;

endpackage

// ===== hw/rtl/vsis_ctrl.sv =====
// vsis_ctrl: command sequencer for the interval summary block.
// Depends on vsis_pkg for the state, command and status types.
module vsis_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_command,
  input  vsis_pkg::ctrl_sts_t  sts,
  output vsis_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);

  vsis_pkg::state_t state_r;
  vsis_pkg::state_t state_nxt;
  logic             accept;

  assign accept = start && (state_r == vsis_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      vsis_pkg::ST_IDLE: begin
        if (accept && (in_command == vsis_pkg::CMD_REPORT)) begin
          state_nxt = vsis_pkg::ST_SCAN;
        end
      end
      vsis_pkg::ST_SCAN: begin
        if (sts.at_last) begin
          state_nxt = vsis_pkg::ST_FLUSH;
        end
      end
      vsis_pkg::ST_FLUSH: begin
        state_nxt = vsis_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = vsis_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      vsis_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd.insert    = accept && (in_command == vsis_pkg::CMD_INSERT);
        cmd.scan_init = accept && (in_command == vsis_pkg::CMD_REPORT);
      end
      vsis_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      vsis_pkg::ST_FLUSH: begin
        cmd.flush = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vsis_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/vsis_dp.sv =====
// vsis_dp: presence bitmap, scan pointer, run tracking and result register.
// Depends on vsis_pkg; driven by vsis_ctrl through command and status structs.
module vsis_dp #(
  parameter int VALUE_COUNT = vsis_pkg::DEF_VALUE_COUNT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  vsis_pkg::ctrl_cmd_t        cmd,
  output vsis_pkg::ctrl_sts_t        sts,
  input  logic [vsis_pkg::VAL_W-1:0] in_value,
  output logic                       out_valid,
  output logic [vsis_pkg::VAL_W-1:0] out_interval_start,
  output logic [vsis_pkg::VAL_W-1:0] out_interval_end,
  output logic                       out_last_interval
);

  localparam int IDX_W = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VALUE_COUNT - 1);
  localparam logic [vsis_pkg::VAL_W:0] BOUND = (vsis_pkg::VAL_W + 1)'(VALUE_COUNT);

  logic [VALUE_COUNT-1:0] seen_r, seen_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic                   in_run_r, in_run_nxt;
  logic [IDX_W-1:0]       run_lo_r, run_lo_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [IDX_W-1:0]       pend_lo_r, pend_lo_nxt;
  logic [IDX_W-1:0]       pend_hi_r, pend_hi_nxt;
  logic                   out_v_r, out_v_nxt;
  logic [IDX_W-1:0]       out_lo_r, out_lo_nxt;
  logic [IDX_W-1:0]       out_hi_r, out_hi_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   in_range;
  logic                   bit_here;
  logic                   is_last;
  logic                   run_done;
  logic [IDX_W-1:0]       done_lo;
  logic [IDX_W-1:0]       done_hi;

  assign in_range = {1'b0, in_value} < BOUND;
  assign bit_here = seen_r[idx_r];
  assign is_last  = (idx_r == LAST_IDX);
  assign sts.at_last = is_last;

  // A run closes on the first clear bit after it, or at the top of the map.
  assign run_done = (!bit_here && in_run_r) || (bit_here && is_last);
  assign done_lo  = in_run_r ? run_lo_r : idx_r;
  assign done_hi  = bit_here ? idx_r : idx_r - 1'b1;

  always_comb begin
    seen_nxt     = seen_r;
    idx_nxt      = idx_r;
    in_run_nxt   = in_run_r;
    run_lo_nxt   = run_lo_r;
    pend_v_nxt   = pend_v_r;
    pend_lo_nxt  = pend_lo_r;
    pend_hi_nxt  = pend_hi_r;
    out_v_nxt    = 1'b0;
    out_lo_nxt   = out_lo_r;
    out_hi_nxt   = out_hi_r;
    out_last_nxt = out_last_r;

    if (cmd.insert && in_range) begin
      seen_nxt[in_value[IDX_W-1:0]] = 1'b1;
    end

    if (cmd.scan_init) begin
      idx_nxt    = '0;
      in_run_nxt = 1'b0;
      pend_v_nxt = 1'b0;
    end

    if (cmd.scan_step) begin
      idx_nxt = idx_r + 1'b1;
      if (bit_here && !in_run_r) begin
        run_lo_nxt = idx_r;
      end
      in_run_nxt = bit_here;
      if (run_done) begin
        // hold the closed run until we know whether another one follows
        if (pend_v_r) begin
          out_v_nxt    = 1'b1;
          out_lo_nxt   = pend_lo_r;
          out_hi_nxt   = pend_hi_r;
          out_last_nxt = 1'b0;
        end
        pend_v_nxt  = 1'b1;
        pend_lo_nxt = done_lo;
        pend_hi_nxt = done_hi;
      end
    end

    if (cmd.flush) begin
      out_v_nxt    = pend_v_r;
      out_lo_nxt   = pend_lo_r;
      out_hi_nxt   = pend_hi_r;
      out_last_nxt = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      idx_r    <= '0;
      in_run_r <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      seen_r   <= seen_nxt;
      idx_r    <= idx_nxt;
      in_run_r <= in_run_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_lo_r   <= run_lo_nxt;
    pend_lo_r  <= pend_lo_nxt;
    pend_hi_r  <= pend_hi_nxt;
    out_lo_r   <= out_lo_nxt;
    out_hi_r   <= out_hi_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid          = out_v_r;
  assign out_interval_start = vsis_pkg::VAL_W'(out_lo_r);
  assign out_interval_end   = vsis_pkg::VAL_W'(out_hi_r);
  assign out_last_interval  = out_last_r;

endmodule

// ===== hw/rtl/value_set_interval_summary.sv =====
// value_set_interval_summary: insert leaves busy low.
// Report holds busy through the scan and a flush step; one bitmap bit is scanned per cycle.
// Each run appears for one cycle on out_valid once the next run closes; the
// final run, flagged last, appears in the same cycle that busy falls. No stall input.
// Synchronous active-low reset clears the bitmap and returns the block to idle.
// Depends on vsis_pkg, vsis_ctrl and vsis_dp.
module value_set_interval_summary #(
  parameter int VALUE_COUNT = vsis_pkg::DEF_VALUE_COUNT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_command,
  input  logic [vsis_pkg::VAL_W-1:0] in_value,
  output logic                       out_valid,
  output logic [vsis_pkg::VAL_W-1:0] out_interval_start,
  output logic [vsis_pkg::VAL_W-1:0] out_interval_end,
  output logic                       out_last_interval
);

  vsis_pkg::ctrl_cmd_t cmd;
  vsis_pkg::ctrl_sts_t sts;

  vsis_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy)
  );

  vsis_dp #(
    .VALUE_COUNT (VALUE_COUNT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_interval_start (out_interval_start),
    .out_interval_end   (out_interval_end),
    .out_last_interval  (out_last_interval)
  );

  a_report_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_command == vsis_pkg::CMD_REPORT) |=> busy)
    else $error("report accepted without entering scan");

  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_interval_start <= out_interval_end))
    else $error("run start above run end");

  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !busy |-> out_last_interval)
    else $error("non-final run emitted while idle");

  a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_interval |=> !out_valid)
    else $error("result follows the final run of a report");

endmodule
